// ===== rtl/nested_region_timing_profiler_macros.svh =====
// assertion macros for the nested region timing profiler
`ifndef NESTED_REGION_TIMING_PROFILER_MACROS_SVH
`define NESTED_REGION_TIMING_PROFILER_MACROS_SVH

// checked on every clock edge outside reset
`define NRTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define NRTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/nrtp_pkg.sv =====
// shared types and codes of the nested region timing profiler
package nrtp_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIS     = 3'd1;
  localparam logic [2:0] ST_SFULL   = 3'd2;
  localparam logic [2:0] ST_TFULL   = 3'd3;
  localparam logic [2:0] ST_SEMPTY  = 3'd4;
  localparam logic [2:0] ST_UNUSED  = 3'd5;

  typedef struct packed {
    logic [63:0] total;
    logic [31:0] count;
    logic [63:0] min_t;
    logic [63:0] max_t;
  } stats_t;

  localparam stats_t STATS_INIT = '{64'd0, 32'd0, {64{1'b1}}, 64'd0};

  // shift control for the stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// ===== rtl/nrtp_ram.sv =====
// generic single write, single registered read ram
module nrtp_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/nrtp_stack_cell.sv =====
// one slot of the shifting region stack
module nrtp_stack_cell #(
  parameter int EW = 8
) (
  input  logic                 clk_i,
  input  nrtp_pkg::stk_ctrl_t  ctrl_i,
  input  logic [EW-1:0]        up_entry_i,
  input  logic [63:0]          up_time_i,
  input  logic [EW-1:0]        dn_entry_i,
  input  logic [63:0]          dn_time_i,
  output logic [EW-1:0]        entry_o,
  output logic [63:0]          time_o
);
  import nrtp_pkg::*;

  logic [EW-1:0] entry_q;
  logic [63:0]   time_q;

  // push takes the slot above, pop takes the slot below
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      entry_q <= up_entry_i;
      time_q  <= up_time_i;
    end else if (ctrl_i.pop) begin
      entry_q <= dn_entry_i;
      time_q  <= dn_time_i;
    end
  end

  assign entry_o = entry_q;
  assign time_o  = time_q;
endmodule

// ===== rtl/nested_region_timing_profiler.sv =====
// top level of the nested region timing profiler
//
// input channel: in_valid_i / in_stall_o with operation, region_tag, timestamp
// and entry_index; one word in gives exactly one result word out on
// out_valid_o / out_stall_i. the enable register is written on cfg_valid_i
// while cfg_ready_o (always high); the user must write it only while the
// block is idle, the block itself does not enforce this. one word at a
// time: start walks the tag ram one entry per cycle, and clear sweeps the
// used rows of the statistics ram.
// the finished result sits in an output register, so a new word is taken
// while the receiver stalls; the block only waits for the receiver when a
// second result is ready before the first was taken.
// reset empties the stack and the table and clears enable; no clearing
// pass is needed since rows are initialized when allocated.
// the open region stack is a chain of cells: push shifts every slot down
// by one, pop shifts every slot up by one, the top sits in cell zero.
module nested_region_timing_profiler #(
  parameter int TABLE_ENTRIES = 256,
  parameter int STACK_DEPTH   = 32,
  parameter int TAG_BITS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] region_tag_i,
  input  logic [63:0] timestamp_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  entry_number_o,
  output logic [63:0] dur_sum_o,
  output logic [31:0] event_count_o,
  output logic [63:0] dur_min_o,
  output logic [63:0] dur_max_o,
  output logic [31:0] tag_out_o,
  output logic [5:0]  nesting_depth_o,
  output logic [8:0]  entries_used_o
);
  import nrtp_pkg::*;

  `include "nested_region_timing_profiler_macros.svh"

  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int SW = $bits(stats_t);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_USE  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]    st_q, st_d;
  logic          enable_q;
  logic [1:0]    op_q, op_d;
  logic [TW-1:0] tag_q, tag_d;
  logic [63:0]   now_q, now_d;
  logic [63:0]   start_q, start_d;
  logic [EW-1:0] e_q, e_d;
  logic [UW-1:0] ptr_q, ptr_d;
  logic          cmp_v_q, cmp_v_d;
  logic [EW-1:0] cmp_idx_q, cmp_idx_d;
  logic [LW-1:0] level_q, level_d;
  logic [UW-1:0] used_q, used_d;

  // staged result
  logic [2:0]    res_status_q, res_status_d;
  logic          res_has_q, res_has_d;
  logic [EW-1:0] res_entry_q, res_entry_d;
  stats_t        res_stats_q, res_stats_d;
  logic [TW-1:0] res_tag_q, res_tag_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [2:0]    out_status_q;
  logic [7:0]    out_entry_q;
  stats_t        out_stats_q;
  logic [31:0]   out_tag_q;
  logic [5:0]    out_depth_q;
  logic [8:0]    out_used_q;

  // rams
  logic          tag_we;
  logic [EW-1:0] tag_waddr;
  logic [TW-1:0] tag_wdata, tag_rdata;
  logic          sts_we;
  logic [EW-1:0] sts_waddr;
  stats_t        sts_wdata, sts_rdata;
  logic [EW-1:0] rd_addr;

  // stack chain
  stk_ctrl_t     stk_ctrl;
  logic [EW-1:0] push_entry;
  logic [EW-1:0] cell_entry [STACK_DEPTH];
  logic [63:0]   cell_time  [STACK_DEPTH];

  logic          in_acc;
  logic [63:0]   dur;
  stats_t        upd;

  nrtp_ram #(.W(TW), .D(TABLE_ENTRIES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (rd_addr),
    .rdata_o (tag_rdata)
  );

  nrtp_ram #(.W(SW), .D(TABLE_ENTRIES)) u_sts_ram (
    .clk_i   (clk_i),
    .we_i    (sts_we),
    .waddr_i (sts_waddr),
    .wdata_i (sts_wdata),
    .raddr_i (rd_addr),
    .rdata_o (sts_rdata)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [EW-1:0] up_e, dn_e;
    logic [63:0]   up_t, dn_t;
    if (i == 0) begin : g_top
      assign up_e = push_entry;
      assign up_t = now_q;
    end else begin : g_mid
      assign up_e = cell_entry[i-1];
      assign up_t = cell_time[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_e = '0;
      assign dn_t = '0;
    end else begin : g_up
      assign dn_e = cell_entry[i+1];
      assign dn_t = cell_time[i+1];
    end
    nrtp_stack_cell #(.EW(EW)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (stk_ctrl),
      .up_entry_i (up_e),
      .up_time_i  (up_t),
      .dn_entry_i (dn_e),
      .dn_time_i  (dn_t),
      .entry_o    (cell_entry[i]),
      .time_o     (cell_time[i])
    );
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (st_q == S_WAIT) && (!out_valid_q || !out_stall_i);

  // statistics fold for an end word
  assign dur = now_q - start_q;
  always_comb begin
    upd       = sts_rdata;
    upd.total = sts_rdata.total + dur;
    upd.count = sts_rdata.count + 32'd1;
    if (dur < sts_rdata.min_t) begin
      upd.min_t = dur;
    end
    if (dur > sts_rdata.max_t) begin
      upd.max_t = dur;
    end
  end

  always_comb begin
    st_d         = st_q;
    op_d         = op_q;
    tag_d        = tag_q;
    now_d        = now_q;
    start_d      = start_q;
    e_d          = e_q;
    ptr_d        = ptr_q;
    cmp_v_d      = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    level_d      = level_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_has_d    = res_has_q;
    res_entry_d  = res_entry_q;
    res_stats_d  = res_stats_q;
    res_tag_d    = res_tag_q;
    tag_we       = 1'b0;
    tag_waddr    = used_q[EW-1:0];
    tag_wdata    = tag_q;
    sts_we       = 1'b0;
    sts_waddr    = e_q;
    sts_wdata    = STATS_INIT;
    rd_addr      = e_q;
    stk_ctrl     = '0;
    push_entry   = e_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d        = operation_i;
          tag_d       = region_tag_i[TW-1:0];
          now_d       = timestamp_i;
          ptr_d       = '0;
          res_has_d   = 1'b0;
          res_status_d = ST_OK;
          st_d        = S_WAIT;
          if (!enable_q) begin
            res_status_d = ST_DIS;
          end else begin
            unique case (operation_i)
              OP_START: begin
                if (level_q >= LW'(STACK_DEPTH)) begin
                  res_status_d = ST_SFULL;
                end else begin
                  st_d = S_SRCH;
                end
              end
              OP_END: begin
                if (level_q == '0) begin
                  res_status_d = ST_SEMPTY;
                end else begin
                  e_d          = cell_entry[0];
                  start_d      = cell_time[0];
                  stk_ctrl.pop = 1'b1;
                  level_d      = level_q - LW'(1);
                  st_d         = S_RD;
                end
              end
              OP_CLEAR: begin
                st_d = S_CLR;
              end
              default: begin
                if ((int'(entry_index_i) >= int'(used_q))
                    || (int'(entry_index_i) >= TABLE_ENTRIES)) begin
                  res_status_d = ST_UNUSED;
                end else begin
                  e_d  = EW'(entry_index_i);
                  st_d = S_RD;
                end
              end
            endcase
          end
        end
      end
      S_SRCH: begin
        // one tag read issued per cycle, compared in the cycle after
        rd_addr = ptr_q[EW-1:0];
        if (cmp_v_q && (tag_rdata == tag_q)) begin
          e_d           = cmp_idx_q;
          push_entry    = cmp_idx_q;
          stk_ctrl.push = 1'b1;
          level_d       = level_q + LW'(1);
          st_d          = S_RD;
        end else if (ptr_q < used_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = ptr_q[EW-1:0];
          ptr_d     = ptr_q + UW'(1);
        end else if (!cmp_v_q) begin
          st_d = S_WAIT;
          if (used_q == UW'(TABLE_ENTRIES)) begin
            res_status_d = ST_TFULL;
          end else begin
            // allocate a fresh row
            tag_we        = 1'b1;
            sts_we        = 1'b1;
            sts_waddr     = used_q[EW-1:0];
            push_entry    = used_q[EW-1:0];
            stk_ctrl.push = 1'b1;
            level_d       = level_q + LW'(1);
            used_d        = used_q + UW'(1);
            res_has_d     = 1'b1;
            res_entry_d   = used_q[EW-1:0];
            res_stats_d   = STATS_INIT;
            res_tag_d     = tag_q;
          end
        end
      end
      S_RD: begin
        st_d = S_USE;
      end
      S_USE: begin
        res_has_d   = 1'b1;
        res_entry_d = e_q;
        res_tag_d   = tag_rdata;
        res_stats_d = sts_rdata;
        if (op_q == OP_END) begin
          sts_we      = 1'b1;
          sts_wdata   = upd;
          res_stats_d = upd;
        end
        st_d = S_WAIT;
      end
      S_CLR: begin
        if (ptr_q < used_q) begin
          sts_we    = 1'b1;
          sts_waddr = ptr_q[EW-1:0];
          ptr_d     = ptr_q + UW'(1);
        end else begin
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      enable_q    <= 1'b0;
      level_q     <= '0;
      used_q      <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      level_q     <= level_d;
      used_q      <= used_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tag_q        <= tag_d;
    now_q        <= now_d;
    start_q      <= start_d;
    e_q          <= e_d;
    ptr_q        <= ptr_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_has_q    <= res_has_d;
    res_entry_q  <= res_entry_d;
    res_stats_q  <= res_stats_d;
    res_tag_q    <= res_tag_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_depth_q  <= 6'(level_q);
      out_used_q   <= 9'(used_q);
      if (res_has_q) begin
        out_entry_q <= 8'(res_entry_q);
        out_stats_q <= res_stats_q;
        out_tag_q   <= 32'(res_tag_q);
      end else begin
        out_entry_q <= '0;
        out_stats_q <= '0;
        out_tag_q   <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign entry_number_o  = out_entry_q;
  assign dur_sum_o       = out_stats_q.total;
  assign event_count_o   = out_stats_q.count;
  assign dur_min_o       = out_stats_q.min_t;
  assign dur_max_o       = out_stats_q.max_t;
  assign tag_out_o       = out_tag_q;
  assign nesting_depth_o = out_depth_q;
  assign entries_used_o  = out_used_q;

  `NRTP_ASSERT(a_level_range, level_q <= LW'(STACK_DEPTH), "stack level beyond depth")
  `NRTP_ASSERT(a_used_range, used_q <= UW'(TABLE_ENTRIES), "table count beyond size")
  `NRTP_ASSERT(a_load_shows, out_load |=> out_valid_q, "staged result not presented")
  `NRTP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> (st_q == S_IDLE), "busy during reset")
endmodule
